@@ rtl/core/chs_pkg.sv @@
// Shared field widths, operation and status codes for the chained hash set.
package chs_pkg;

	// Beat field widths
	localparam int MODE_W         = 2;
	localparam int KEY_W          = 31;
	localparam int STATUS_W       = 3;
	localparam int BUCKET_FIELD_W = 4;

	// Stream bus data widths, padded to whole bytes
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 8;

	// One bucket slot in memory: key plus its occupied flag on top
	localparam int ENTRY_W = KEY_W + 1;

	typedef logic [MODE_W-1:0]   mode_t;
	typedef logic [STATUS_W-1:0] status_t;

	// Operation codes; the unused code behaves as a search
	localparam mode_t MODE_INSERT = 2'd0;
	localparam mode_t MODE_REMOVE = 2'd1;
	localparam mode_t MODE_SEARCH = 2'd2;

	// Result status codes
	localparam status_t ST_INSERTED  = 3'd0;
	localparam status_t ST_DUPLICATE = 3'd1;
	localparam status_t ST_FOUND     = 3'd2;
	localparam status_t ST_ABSENT    = 3'd3;
	localparam status_t ST_FULL      = 3'd4;

endpackage

@@ rtl/core/chs_ram.sv @@
// Generic simple dual-port RAM with registered read.
module chs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/chs_front.sv @@
// Front end: takes input beats and works out the bucket index (key mod BUCKETS).
module chs_front import chs_pkg::*; #(
	parameter int BUCKETS = 16,
	parameter int BW      = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	// input beat
	input  logic          in_valid,
	output logic          in_ready,
	input  mode_t         in_mode,
	input  logic [KEY_W-1:0] in_key,
	// back end still clearing memory
	input  logic          clearing,
	// classified item toward the queue
	output logic          out_valid,
	input  logic          out_ready,
	output mode_t         out_mode,
	output logic [KEY_W-1:0] out_key,
	output logic [BW-1:0] out_idx
);

	// Reciprocal of BUCKETS scaled by 2^(KEY_W+BW), rounded up: exact quotient for any key
	localparam int               SHIFT  = KEY_W + BW;
	localparam int               RCP_W  = KEY_W + 1;
	localparam int               PROD_W = KEY_W + RCP_W;
	localparam longint           RCP_L  = ((longint'(1) <<< SHIFT) + longint'(BUCKETS) - 1)
		/ longint'(BUCKETS);
	localparam logic [RCP_W-1:0] RCP    = RCP_W'(RCP_L);
	localparam logic [BW-1:0]    B_LO   = BW'(BUCKETS);

	typedef enum logic [1:0] {F_IDLE, F_MUL, F_REM, F_HOLD} fstate_t;

	fstate_t             state_q;
	logic [KEY_W-1:0]    key_q;
	mode_t               mode_q;
	logic [BW-1:0]       quo_q;
	logic [BW-1:0]       rem_q;
	logic [PROD_W-1:0]   prod;
	logic                accept;

	// Handshakes
	assign in_ready  = !clearing && ((state_q == F_IDLE) || ((state_q == F_HOLD) && out_ready));
	assign accept    = in_valid && in_ready;
	assign out_valid = (state_q == F_HOLD);
	assign out_mode  = mode_q;
	assign out_key   = key_q;
	assign out_idx   = rem_q;

	// Key times reciprocal; the quotient sits from bit SHIFT up
	assign prod = PROD_W'(key_q) * PROD_W'(RCP);

	// Sequencer: multiply, then subtract; the remainder is below 2^BW, so low bits suffice
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			key_q   <= '0;
			mode_q  <= MODE_INSERT;
			quo_q   <= '0;
			rem_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE, F_HOLD: begin
					if (accept) begin
						key_q   <= in_key;
						mode_q  <= in_mode;
						state_q <= F_MUL;
					end else if ((state_q == F_HOLD) && out_ready) begin
						state_q <= F_IDLE;
					end
				end
				F_MUL: begin
					quo_q   <= prod[SHIFT +: BW];
					state_q <= F_REM;
				end
				F_REM: begin
					rem_q   <= key_q[BW-1:0] - quo_q * B_LO;
					state_q <= F_HOLD;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// A new key is only loaded once the previous item has left
	a_accept_free: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (state_q == F_IDLE) || out_ready)
		else $error("front accepted a beat over an unsent item");

endmodule

@@ rtl/core/chs_queue.sv @@
// Short FIFO decoupling the front end from the back end.
module chs_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop,
	output logic [W-1:0] pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  entry_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = entry_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue fill count out of range");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("queue popped while empty");

endmodule

@@ rtl/core/chs_back.sv @@
// Back end: clears the bucket memory, then per item reads, scans and rewrites if changed.
module chs_back import chs_pkg::*; #(
	parameter int BUCKETS = 16,
	parameter int WAYS    = 4,
	parameter int BW      = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	// item from the queue
	input  logic          q_valid,
	output logic          q_pop,
	input  mode_t         q_mode,
	input  logic [KEY_W-1:0] q_key,
	input  logic [BW-1:0] q_idx,
	// memory clearing pass in progress
	output logic          clearing,
	// result beat
	output logic          res_valid,
	input  logic          res_ready,
	output status_t       res_status,
	output logic [BUCKET_FIELD_W-1:0] res_bucket
);

	localparam int ROW_W = WAYS * ENTRY_W;

	typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_READ, B_CMP} bstate_t;

	bstate_t          state_q;
	logic [BW-1:0]    clr_q;
	mode_t            mode_q;
	logic [KEY_W-1:0] key_q;
	logic [BW-1:0]    idx_q;
	logic [WAYS-1:0]  match_q;
	logic [WAYS-1:0]  valid_q;
	logic             out_valid_q;
	status_t          out_status_q;
	logic [BUCKET_FIELD_W-1:0] out_bucket_q;

	logic             ram_we;
	logic [BW-1:0]    ram_waddr;
	logic [ROW_W-1:0] ram_wdata;
	logic [ROW_W-1:0] ram_rdata;
	logic [ROW_W-1:0] new_row;
	logic [WAYS-1:0]  rd_match;
	logic [WAYS-1:0]  rd_valid;
	logic [WAYS-1:0]  free_v;
	logic [WAYS-1:0]  hit_oh;
	logic [WAYS-1:0]  free_oh;
	logic [WAYS-1:0]  new_valid;
	logic             hit;
	logic             ins_ok;
	logic             rem_ok;
	logic             can_load;
	status_t          status_nxt;

	chs_ram #(.WIDTH(ROW_W), .DEPTH(BUCKETS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (q_pop),
		.raddr (q_idx),
		.rdata (ram_rdata)
	);

	assign clearing   = (state_q == B_CLEAR);
	assign q_pop      = (state_q == B_IDLE) && q_valid;
	assign res_valid  = out_valid_q;
	assign res_status = out_status_q;
	assign res_bucket = out_bucket_q;
	assign can_load   = !out_valid_q || res_ready;

	// Compare every way of the read row against the key
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			rd_valid[w] = ram_rdata[w*ENTRY_W + KEY_W];
			rd_match[w] = rd_valid[w] && (ram_rdata[w*ENTRY_W +: KEY_W] == key_q);
		end
	end

	// Lowest matching way and lowest free way, isolated as one-hot
	assign free_v  = ~valid_q;
	assign hit_oh  = match_q & (~match_q + WAYS'(1));
	assign free_oh = free_v & (~free_v + WAYS'(1));
	assign hit     = |match_q;

	// Decide status and the row update
	always_comb begin
		ins_ok     = 1'b0;
		rem_ok     = 1'b0;
		status_nxt = hit ? ST_FOUND : ST_ABSENT;
		priority if (mode_q == MODE_INSERT) begin
			if (hit) begin
				status_nxt = ST_DUPLICATE;
			end else if (|free_v) begin
				ins_ok     = 1'b1;
				status_nxt = ST_INSERTED;
			end else begin
				status_nxt = ST_FULL;
			end
		end else if (mode_q == MODE_REMOVE) begin
			rem_ok = hit;
		end else begin
			status_nxt = hit ? ST_FOUND : ST_ABSENT;
		end
	end

	always_comb begin
		if (ins_ok) begin
			new_valid = valid_q | free_oh;
		end else if (rem_ok) begin
			new_valid = valid_q & ~hit_oh;
		end else begin
			new_valid = valid_q;
		end
		for (int w = 0; w < WAYS; w++) begin
			new_row[w*ENTRY_W +: KEY_W] = (ins_ok && free_oh[w]) ?
				key_q : ram_rdata[w*ENTRY_W +: KEY_W];
			new_row[w*ENTRY_W + KEY_W] = new_valid[w];
		end
	end

	// Memory write: zero rows while clearing, else the updated bucket
	assign ram_we    = clearing || ((state_q == B_CMP) && can_load && (ins_ok || rem_ok));
	assign ram_waddr = clearing ? clr_q : idx_q;
	assign ram_wdata = clearing ? '0 : new_row;

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_CLEAR;
			clr_q        <= '0;
			mode_q       <= MODE_INSERT;
			key_q        <= '0;
			idx_q        <= '0;
			match_q      <= '0;
			valid_q      <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_INSERTED;
			out_bucket_q <= '0;
		end else begin
			if (out_valid_q && res_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BW'(BUCKETS - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (q_valid) begin
						mode_q  <= q_mode;
						key_q   <= q_key;
						idx_q   <= q_idx;
						state_q <= B_READ;
					end
				end
				B_READ: begin
					match_q <= rd_match;
					valid_q <= rd_valid;
					state_q <= B_CMP;
				end
				B_CMP: begin
					if (can_load) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_nxt;
						out_bucket_q <= BUCKET_FIELD_W'(idx_q);
						state_q      <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	a_we_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == B_CLEAR) || (state_q == B_CMP))
		else $error("bucket memory written outside clear or update");

	a_update_result: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && (state_q == B_CMP)) |=> out_valid_q)
		else $error("bucket update without a result beat");

	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !q_pop)
		else $error("item taken during memory clearing");

endmodule

@@ rtl/core/chained_hash_set.sv @@
// Chained hash set: insert, remove and search of 31-bit keys in a bucketed table.
//
// Input channel s_*: one beat per operation (mode, key). Output channel m_*:
// one beat per operation (status, bucket), in input order.
// The bucket index is key mod BUCKETS; each bucket holds up to WAYS keys.
// A front end works out the bucket index (multiply by a scaled reciprocal
// of BUCKETS, then subtract) and hands the item to a two-entry queue. A
// back end reads the whole bucket row from memory, compares all ways, then
// writes the row back if it changed and loads the output register.
// The front end takes a new beat only when idle or as its last item goes to
// the queue; the back end works on one item at a time: pop, read, compare.
// Reset: the bucket memory is cleared one row a cycle, every row, with
// s_tready low; then items are taken.
// A stalled output holds its beat; the queue fills and then s_tready drops.
module chained_hash_set import chs_pkg::*; #(
	parameter int BUCKETS = 16,
	parameter int WAYS    = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // [1:0] mode, [32:2] key, rest zero
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata    // [2:0] status, [6:3] bucket, rest zero
);

	localparam int BW    = $clog2(BUCKETS);
	localparam int QW    = MODE_W + KEY_W + BW;
	localparam int QDEPTH = 2;

	logic             clearing;
	logic             fr_valid;
	logic             fr_ready;
	mode_t            fr_mode;
	logic [KEY_W-1:0] fr_key;
	logic [BW-1:0]    fr_idx;
	logic             q_valid;
	logic             q_pop;
	logic [QW-1:0]    q_data;
	status_t          res_status;
	logic [BUCKET_FIELD_W-1:0] res_bucket;

	chs_front #(.BUCKETS(BUCKETS), .BW(BW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tdata[MODE_W-1:0]),
		.in_key    (s_tdata[MODE_W +: KEY_W]),
		.clearing  (clearing),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_mode  (fr_mode),
		.out_key   (fr_key),
		.out_idx   (fr_idx)
	);

	chs_queue #(.W(QW), .DEPTH(QDEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_data  ({fr_idx, fr_key, fr_mode}),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_data   (q_data)
	);

	chs_back #(.BUCKETS(BUCKETS), .WAYS(WAYS), .BW(BW)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_mode     (q_data[MODE_W-1:0]),
		.q_key      (q_data[MODE_W +: KEY_W]),
		.q_idx      (q_data[MODE_W + KEY_W +: BW]),
		.clearing   (clearing),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res_status (res_status),
		.res_bucket (res_bucket)
	);

	// Output beat packing
	assign m_tdata = M_DATA_W'({res_bucket, res_status});

endmodule
